// ----- design/rbsi_pkg.sv -----
// Shared types and constants for the ray/box segment intersection block.
`timescale 1ns / 1ps
package rbsi_pkg;

    localparam int POS_W       = 32;
    localparam int DIR_W       = 32;
    localparam int LEN_W       = 31;
    localparam int MAG_W       = 32;
    localparam int NUM_W       = 34;
    localparam int DIR_SHIFT   = 30;
    localparam int QUO_W       = MAG_W + DIR_SHIFT;
    localparam int PROD_W      = 64;
    localparam int C_W         = 36;
    localparam int QUEUE_DEPTH = 4;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int CFG_ADDR_W  = 2;

    localparam logic [1:0] OP_EXIT    = 2'd0;
    localparam logic [1:0] OP_ENTRY   = 2'd1;
    localparam logic [1:0] OP_CONTAIN = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_Z = 2'd2;

    typedef struct packed {
        logic [2:0][LEN_W-1:0] size;
    } t_cfg;

    typedef struct packed {
        logic [1:0]            op;
        logic [2:0][POS_W-1:0] rp;
        logic [2:0][DIR_W-1:0] ud;
        logic [LEN_W-1:0]      len;
        logic [2:0]            nneg;
        logic [2:0]            beyond;
        logic                  inbox;
    } t_pay;

    typedef struct packed {
        t_pay                  pay;
        logic [2:0][MAG_W-1:0] nmag;
    } t_item;

endpackage

// ----- design/ray_box_segment_intersect.sv -----
// Top level of the ray/box segment intersection block.
`timescale 1ns / 1ps
// Takes one word per clock while o_in_stall is low and returns one word per
// input word, in order, via the one-bit-per-stage face distance dividers, the
// clamp, multiply and face point check stages and the output register. A
// four-word queue separates the front end from the back end, which advances
// whenever the output register is free. The user must write box sizes through
// the config port only while the block is idle; the block does not enforce it.
module ray_box_segment_intersect #(
    parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rbsi_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [rbsi_pkg::LEN_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_operation,
    input  logic [rbsi_pkg::POS_W-1:0]         i_pos_x,
    input  logic [rbsi_pkg::POS_W-1:0]         i_pos_y,
    input  logic [rbsi_pkg::POS_W-1:0]         i_pos_z,
    input  logic [rbsi_pkg::DIR_W-1:0]         i_dir_x,
    input  logic [rbsi_pkg::DIR_W-1:0]         i_dir_y,
    input  logic [rbsi_pkg::DIR_W-1:0]         i_dir_z,
    input  logic [rbsi_pkg::LEN_W-1:0]         i_seg_length,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_hit,
    output logic [rbsi_pkg::LEN_W-1:0]         o_distance
);
    rbsi_pkg::t_cfg  r_cfg;
    rbsi_pkg::t_item w_item, w_qdata;
    logic w_full, w_empty, w_en, w_push, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rbsi_pkg::CFG_SIZE_X: r_cfg.size[0] <= i_cfg_data;
                rbsi_pkg::CFG_SIZE_Y: r_cfg.size[1] <= i_cfg_data;
                rbsi_pkg::CFG_SIZE_Z: r_cfg.size[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rbsi_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_op   (i_operation),
        .i_pos  ({i_pos_z, i_pos_y, i_pos_x}),
        .i_dir  ({i_dir_z, i_dir_y, i_dir_x}),
        .i_len  (i_seg_length),
        .i_cfg  (r_cfg),
        .o_item (w_item)
    );

    assign o_in_stall = w_full;
    assign w_push     = i_in_valid && !w_full;
    assign w_pop      = w_en && !w_empty;

    rbsi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_qdata)
    );

    rbsi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_pop),
        .i_item      (w_qdata),
        .i_cfg       (r_cfg),
        .i_out_stall (i_out_stall),
        .o_en        (w_en),
        .o_out_valid (o_out_valid),
        .o_hit       (o_hit),
        .o_distance  (o_distance)
    );

endmodule

// ----- design/rbsi_front.sv -----
// Front end: sign extension, face selection, face numerators and containment.
`timescale 1ns / 1ps
module rbsi_front #(
    parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF
) (
    input  logic [1:0]                      i_op,
    input  logic [2:0][rbsi_pkg::POS_W-1:0] i_pos,
    input  logic [2:0][rbsi_pkg::DIR_W-1:0] i_dir,
    input  logic [rbsi_pkg::LEN_W-1:0]      i_len,
    input  rbsi_pkg::t_cfg                  i_cfg,
    output rbsi_pkg::t_item                 o_item
);
    localparam int PW = (COORD_WIDTH < rbsi_pkg::POS_W) ? COORD_WIDTH : rbsi_pkg::POS_W;
    localparam int SH = rbsi_pkg::POS_W - PW;

    always_comb begin
        logic [rbsi_pkg::POS_W-1:0] v_sh;
        logic signed [rbsi_pkg::POS_W-1:0] v_rp;
        logic signed [rbsi_pkg::NUM_W-1:0] v_rpw;
        logic signed [rbsi_pkg::NUM_W-1:0] v_bs;
        logic signed [rbsi_pkg::NUM_W-1:0] v_num;
        logic signed [rbsi_pkg::NUM_W-1:0] v_mag;
        logic v_pos;
        logic v_far;
        o_item = '0;
        o_item.pay.op = i_op;
        o_item.pay.len = i_len;
        o_item.pay.ud = i_dir;
        o_item.pay.inbox = 1'b1;
        for (int a = 0; a < 3; a++) begin
            v_sh  = i_pos[a] << SH;
            v_rp  = $signed(v_sh) >>> SH;
            v_rpw = rbsi_pkg::NUM_W'(v_rp);
            v_bs  = $signed({3'b000, i_cfg.size[a]});
            v_pos = !i_dir[a][rbsi_pkg::DIR_W-1] && (i_dir[a] != '0);
            v_far = (i_op == rbsi_pkg::OP_EXIT) ? v_pos : !v_pos;
            v_num = v_far ? (v_bs - v_rpw) : -v_rpw;
            v_mag = v_num[rbsi_pkg::NUM_W-1] ? -v_num : v_num;
            o_item.pay.rp[a]     = v_rp;
            o_item.pay.nneg[a]   = v_num[rbsi_pkg::NUM_W-1];
            o_item.pay.beyond[a] = v_far ? v_num[rbsi_pkg::NUM_W-1] : v_rp[rbsi_pkg::POS_W-1];
            o_item.nmag[a]       = v_mag[rbsi_pkg::MAG_W-1:0];
            if (v_rp[rbsi_pkg::POS_W-1] || (v_rpw > v_bs)) begin
                o_item.pay.inbox = 1'b0;
            end
        end
    end

endmodule

// ----- design/rbsi_queue.sv -----
// Short word queue between the front end and the back end.
`timescale 1ns / 1ps
module rbsi_queue #(
    parameter int DEPTH = rbsi_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rbsi_pkg::t_item i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output rbsi_pkg::t_item o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rbsi_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- design/rbsi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module rbsi_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [rbsi_pkg::MAG_W-1:0]    i_num,
    input  logic [rbsi_pkg::MAG_W-1:0]    i_den,
    output logic [rbsi_pkg::QUO_W-1:0]    o_quo
);
    localparam int QW = rbsi_pkg::QUO_W;
    localparam int MW = rbsi_pkg::MAG_W;

    // stage k holds the partial remainder and quotient after k+1 steps
    logic [MW-1:0] r_rem [QW];
    logic [QW-1:0] r_dq  [QW];
    logic [MW-1:0] r_den [QW-1];

    function automatic logic [MW+QW-1:0] f_step(logic [MW-1:0] rem, logic [QW-1:0] dq,
                                                logic [MW-1:0] den);
        logic [MW:0] v_sh;
        logic v_ge;
        v_sh = {rem, dq[QW-1]};
        v_ge = (v_sh >= {1'b0, den});
        return {(v_ge ? MW'(v_sh - {1'b0, den}) : v_sh[MW-1:0]), dq[QW-2:0], v_ge};
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            {r_rem[0], r_dq[0]} <= f_step('0, {i_num, {rbsi_pkg::DIR_SHIFT{1'b0}}}, i_den);
            r_den[0] <= i_den;
            for (int k = 1; k < QW; k++) begin
                {r_rem[k], r_dq[k]} <= f_step(r_rem[k-1], r_dq[k-1], r_den[k-1]);
            end
            for (int k = 1; k < QW - 1; k++) begin
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_quo = r_dq[QW-1];

endmodule

// ----- design/rbsi_back.sv -----
// Back end: face distances, face point checks, face selection, output register.
`timescale 1ns / 1ps
module rbsi_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  rbsi_pkg::t_item               i_item,
    input  rbsi_pkg::t_cfg                i_cfg,
    input  logic                          i_out_stall,
    output logic                          o_en,
    output logic                          o_out_valid,
    output logic                          o_hit,
    output logic [rbsi_pkg::LEN_W-1:0]    o_distance
);
    localparam int QW = rbsi_pkg::QUO_W;
    localparam int LW = rbsi_pkg::LEN_W;
    localparam int MW = rbsi_pkg::MAG_W;
    localparam int SC = rbsi_pkg::DIR_SHIFT;
    localparam int CW = rbsi_pkg::C_W;

    logic en;
    assign en   = !o_out_valid || !i_out_stall;
    assign o_en = en;

    logic [2:0][MW-1:0] w_den;
    logic [QW-1:0] w_q [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_den[a] = i_item.pay.ud[a][MW-1] ? -i_item.pay.ud[a] : i_item.pay.ud[a];
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_div
        rbsi_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (i_item.nmag[a]),
            .i_den (w_den[a]),
            .o_quo (w_q[a])
        );
    end

    rbsi_pkg::t_pay r_pay [QW];
    logic [QW-1:0]  r_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pay[0] <= i_item.pay;
            for (int k = 1; k < QW; k++) begin
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[QW-2:0], i_valid};
        end
    end

    // stage 1: sign, compares against length, clamped magnitudes
    rbsi_pkg::t_pay     r1_pay;
    logic [2:0][MW-1:0] r1_tcm;
    logic [2:0]         r1_tneg, r1_lt, r1_gt;
    logic [2:0][LW-1:0] r1_dist;

    always_ff @(posedge i_clk) begin
        logic v_neg;
        if (en) begin
            r1_pay <= r_pay[QW-1];
            for (int a = 0; a < 3; a++) begin
                v_neg = (r_pay[QW-1].nneg[a] ^ r_pay[QW-1].ud[a][MW-1]) && (w_q[a] != '0);
                r1_tneg[a] <= v_neg;
                r1_lt[a]   <= v_neg || (w_q[a] < QW'(r_pay[QW-1].len));
                r1_gt[a]   <= !v_neg && (w_q[a] > QW'(r_pay[QW-1].len));
                r1_dist[a] <= v_neg ? '0 :
                              ((w_q[a] > QW'({LW{1'b1}})) ? {LW{1'b1}} : w_q[a][LW-1:0]);
                r1_tcm[a]  <= (w_q[a] > QW'({MW{1'b1}})) ? {MW{1'b1}} : w_q[a][MW-1:0];
            end
        end
    end

    // stage 2: products for the two other axes of each face
    rbsi_pkg::t_pay                        r2_pay;
    logic [2:0][1:0][rbsi_pkg::PROD_W-1:0] r2_pm;
    logic [2:0][1:0]                       r2_psg;
    logic [2:0]                            r2_lt, r2_gt;
    logic [2:0][LW-1:0]                    r2_dist;

    always_ff @(posedge i_clk) begin
        int b;
        logic [MW-1:0] v_abs;
        if (en) begin
            r2_pay  <= r1_pay;
            r2_lt   <= r1_lt;
            r2_gt   <= r1_gt;
            r2_dist <= r1_dist;
            for (int a = 0; a < 3; a++) begin
                for (int j = 0; j < 2; j++) begin
                    b = (a + j + 1 > 2) ? a + j - 2 : a + j + 1;
                    v_abs = r1_pay.ud[b][MW-1] ? -r1_pay.ud[b] : r1_pay.ud[b];
                    r2_pm[a][j]  <= r1_tcm[a] * v_abs;
                    r2_psg[a][j] <= r1_tneg[a] ^ r1_pay.ud[b][MW-1];
                end
            end
        end
    end

    // stage 3: face point strictly inside the face
    rbsi_pkg::t_pay     r3_pay;
    logic [2:0]         r3_onf, r3_lt, r3_gt;
    logic [2:0][LW-1:0] r3_dist;

    always_ff @(posedge i_clk) begin
        int b;
        logic signed [CW-1:0] v_d, v_c;
        logic v_ok;
        if (en) begin
            r3_pay  <= r2_pay;
            r3_lt   <= r2_lt;
            r3_gt   <= r2_gt;
            r3_dist <= r2_dist;
            for (int a = 0; a < 3; a++) begin
                v_ok = 1'b1;
                for (int j = 0; j < 2; j++) begin
                    b = (a + j + 1 > 2) ? a + j - 2 : a + j + 1;
                    v_d = $signed(CW'(r2_pm[a][j] >> SC));
                    v_c = CW'($signed(r2_pay.rp[b])) + (r2_psg[a][j] ? -v_d : v_d);
                    if (!((v_c > 0) && (v_c < $signed(CW'(i_cfg.size[b]))))) begin
                        v_ok = 1'b0;
                    end
                end
                r3_onf[a] <= v_ok;
            end
        end
    end

    logic [2:0] r_vtail;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtail <= '0;
        end else if (en) begin
            r_vtail <= {r_vtail[1:0], r_vld[QW-1]};
        end
    end

    // face selection
    logic          n_hit;
    logic [LW-1:0] n_dist;

    always_comb begin
        logic [2:0] v_nz;
        logic [1:0] v_ord [3];
        logic v_done;
        logic [1:0] f;
        for (int a = 0; a < 3; a++) begin
            v_nz[a] = (r3_pay.ud[a] != '0);
        end
        n_hit  = 1'b0;
        n_dist = '0;
        v_done = 1'b0;
        v_ord[0] = 2'd0;
        v_ord[1] = 2'd1;
        v_ord[2] = 2'd2;
        case (r3_pay.op)
            rbsi_pkg::OP_EXIT: begin
                if (!r3_pay.ud[0][MW-1] && r3_pay.ud[0] != '0) begin
                    v_ord[0] = 2'd0;
                end else begin
                    v_ord[0] = (!r3_pay.ud[1][MW-1] && r3_pay.ud[1] != '0) ? 2'd1 : 2'd0;
                end
                v_ord[1] = (v_ord[0] == 2'd0) ? 2'd1 : 2'd0;
                for (int i = 0; i < 2; i++) begin
                    f = v_ord[i];
                    if (!v_done && v_nz[f] && r3_onf[f]) begin
                        n_hit  = r3_lt[f];
                        n_dist = r3_dist[f];
                        v_done = 1'b1;
                    end
                end
                if (!v_done && v_nz[2]) begin
                    n_hit  = r3_lt[2];
                    n_dist = r3_dist[2];
                end
            end
            rbsi_pkg::OP_ENTRY: begin
                if (!r3_pay.ud[0][MW-1] && r3_pay.ud[0] != '0 &&
                    (r3_pay.ud[1][MW-1] || r3_pay.ud[1] == '0)) begin
                    v_ord[0] = 2'd1;
                    v_ord[1] = 2'd0;
                end else begin
                    v_ord[0] = 2'd0;
                    v_ord[1] = 2'd1;
                end
                for (int i = 0; i < 3; i++) begin
                    f = v_ord[i];
                    if (!v_done && r3_pay.beyond[f] && v_nz[f]) begin
                        if (r3_gt[f]) begin
                            v_done = 1'b1;
                        end else if (r3_onf[f]) begin
                            n_hit  = 1'b1;
                            n_dist = r3_dist[f];
                            v_done = 1'b1;
                        end
                    end
                end
            end
            rbsi_pkg::OP_CONTAIN: begin
                n_hit = r3_pay.inbox;
            end
            default: begin
                n_hit = 1'b0;
            end
        endcase
        if (!n_hit || r3_pay.op == rbsi_pkg::OP_CONTAIN) begin
            n_dist = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= r_vtail[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_hit      <= n_hit;
            o_distance <= n_dist;
        end
    end

endmodule

// ----- bench/rbsi_checker.sv -----
// Checker: predicts each result word of the ray/box block and compares it with the output.
`timescale 1ns / 1ps
module rbsi_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rbsi_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [rbsi_pkg::LEN_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [1:0]                      i_operation,
    input  logic [rbsi_pkg::POS_W-1:0]      i_pos_x,
    input  logic [rbsi_pkg::POS_W-1:0]      i_pos_y,
    input  logic [rbsi_pkg::POS_W-1:0]      i_pos_z,
    input  logic [rbsi_pkg::DIR_W-1:0]      i_dir_x,
    input  logic [rbsi_pkg::DIR_W-1:0]      i_dir_y,
    input  logic [rbsi_pkg::DIR_W-1:0]      i_dir_z,
    input  logic [rbsi_pkg::LEN_W-1:0]      i_seg_length,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic                            i_hit,
    input  logic [rbsi_pkg::LEN_W-1:0]      i_distance,
    output int                              o_fail_cnt,
    output int                              o_pending
);

    localparam longint DSCALE  = 64'sd1073741824;
    localparam longint T_LIMIT = 64'sd4294967295;
    localparam longint D_MAX   = 64'sd2147483647;

    typedef struct packed {
        logic                       hit;
        logic [rbsi_pkg::LEN_W-1:0] distance;
    } t_hit_word;

    logic [rbsi_pkg::LEN_W-1:0] box_size [3];
    longint pt [3];
    longint dv [3];
    longint bx [3];
    t_hit_word hit_q [$];

    function automatic bit face_dist(int a, bit far_face, output longint t);
        longint num;
        t = 0;
        if (dv[a] == 0) return 0;
        num = far_face ? (bx[a] - pt[a]) : -pt[a];
        t = (num * DSCALE) / dv[a];
        return 1;
    endfunction

    function automatic bit on_face(int a, longint t);
        longint tc;
        longint c;
        tc = t;
        if (tc > T_LIMIT) tc = T_LIMIT;
        if (tc < -T_LIMIT) tc = -T_LIMIT;
        for (int b = 0; b < 3; b++) begin
            if (b != a) begin
                c = pt[b] + (tc * dv[b]) / DSCALE;
                if (!(c > 0 && c < bx[b])) return 0;
            end
        end
        return 1;
    endfunction

    function automatic t_hit_word predict_hit(logic [1:0] op, longint seg);
        t_hit_word w;
        longint t;
        longint tt;
        bit hit;
        bit done;
        bit far_face;
        bit beyond;
        int ord [3];
        t = 0;
        hit = 0;
        done = 0;
        ord[2] = 2;
        case (op)
            rbsi_pkg::OP_EXIT: begin
                if (dv[0] <= 0 && dv[1] > 0) begin
                    ord[0] = 1; ord[1] = 0;
                end else begin
                    ord[0] = 0; ord[1] = 1;
                end
                for (int i = 0; i < 2 && !done; i++) begin
                    if (face_dist(ord[i], dv[ord[i]] > 0, tt) && on_face(ord[i], tt)) begin
                        t = tt;
                        hit = tt < seg;
                        done = 1;
                    end
                end
                if (!done && face_dist(2, dv[2] > 0, tt)) begin
                    t = tt;
                    hit = tt < seg;
                end
            end
            rbsi_pkg::OP_ENTRY: begin
                if (dv[0] > 0 && dv[1] <= 0) begin
                    ord[0] = 1; ord[1] = 0;
                end else begin
                    ord[0] = 0; ord[1] = 1;
                end
                for (int i = 0; i < 3 && !done; i++) begin
                    far_face = !(dv[ord[i]] > 0);
                    beyond = far_face ? (bx[ord[i]] - pt[ord[i]] < 0) : (pt[ord[i]] < 0);
                    if (beyond && face_dist(ord[i], far_face, tt)) begin
                        if (tt > seg) begin
                            done = 1;
                        end else if (on_face(ord[i], tt)) begin
                            t = tt;
                            hit = 1;
                            done = 1;
                        end
                    end
                end
            end
            rbsi_pkg::OP_CONTAIN: begin
                hit = 1;
                for (int i = 0; i < 3; i++)
                    if (!(pt[i] >= 0 && pt[i] <= bx[i])) hit = 0;
            end
            default: hit = 0;
        endcase
        if (t < 0) t = 0;
        if (t > D_MAX) t = D_MAX;
        w.hit = hit;
        w.distance = hit ? t[rbsi_pkg::LEN_W-1:0] : '0;
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_hit_word exp_w;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) box_size[i] <= '0;
            hit_q.delete();
            o_fail_cnt <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we && i_cfg_addr inside {rbsi_pkg::CFG_SIZE_X, rbsi_pkg::CFG_SIZE_Y,
                                               rbsi_pkg::CFG_SIZE_Z})
                box_size[i_cfg_addr] <= i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (hit_q.size() == 0) begin
                    if (o_fail_cnt < 10)
                        $display("unexpected result word hit=%0d distance=%0d",
                                 i_hit, i_distance);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    exp_w = hit_q.pop_front();
                    if (exp_w.hit !== i_hit || exp_w.distance !== i_distance) begin
                        if (o_fail_cnt < 10)
                            $display({"mismatch: expected hit=%0d distance=%0d, ",
                                      "got hit=%0d distance=%0d"},
                                     exp_w.hit, exp_w.distance, i_hit, i_distance);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pt[0] = longint'($signed(i_pos_x));
                pt[1] = longint'($signed(i_pos_y));
                pt[2] = longint'($signed(i_pos_z));
                dv[0] = longint'($signed(i_dir_x));
                dv[1] = longint'($signed(i_dir_y));
                dv[2] = longint'($signed(i_dir_z));
                for (int i = 0; i < 3; i++) bx[i] = longint'({1'b0, box_size[i]});
                hit_q.push_back(predict_hit(i_operation, longint'({1'b0, i_seg_length})));
            end
            o_pending <= hit_q.size();
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top: drives rays and box sizes into the block and reports the verdict.
`timescale 1ns / 1ps
module tb_top;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int UNIT = 1 << 16;
    localparam int DIR_ONE = 1 << 30;
    localparam int MAX_CYCLES = 1_000_000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [rbsi_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [rbsi_pkg::LEN_W-1:0]      i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic [1:0]                      i_operation;
    logic [rbsi_pkg::POS_W-1:0]      i_pos_x, i_pos_y, i_pos_z;
    logic [rbsi_pkg::DIR_W-1:0]      i_dir_x, i_dir_y, i_dir_z;
    logic [rbsi_pkg::LEN_W-1:0]      i_seg_length;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic                            o_hit;
    logic [rbsi_pkg::LEN_W-1:0]      o_distance;
    int                              fail_cnt;
    int                              pending;
    int                              cycle_cnt = 0;
    int                              burst_left;
    int                              stall_mode = 0;
    logic [rbsi_pkg::LEN_W-1:0]      box [3];

    ray_box_segment_intersect dut (.*);

    rbsi_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_operation,
        .i_pos_x, .i_pos_y, .i_pos_z, .i_dir_x, .i_dir_y, .i_dir_z,
        .i_seg_length, .i_out_valid(o_out_valid), .i_out_stall,
        .i_hit(o_hit), .i_distance(o_distance),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stall pattern: switches between free, light and heavy stalling
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 99) < 30);
            default: i_out_stall <= ($urandom_range(0, 99) < 80);
        endcase
    end

    task automatic send_ray(logic [1:0] op, logic [31:0] px, logic [31:0] py,
                            logic [31:0] pz, logic [31:0] dx, logic [31:0] dy,
                            logic [31:0] dz, logic [31:0] seg);
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 40);
        end
        i_operation = op;
        i_pos_x = px; i_pos_y = py; i_pos_z = pz;
        i_dir_x = dx; i_dir_y = dy; i_dir_z = dz;
        i_seg_length = seg[rbsi_pkg::LEN_W-1:0];
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
    endtask

    task automatic drain_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_box(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
        box[0] = sx[rbsi_pkg::LEN_W-1:0];
        box[1] = sy[rbsi_pkg::LEN_W-1:0];
        box[2] = sz[rbsi_pkg::LEN_W-1:0];
        for (int i = 0; i < 3; i++) begin
            @(negedge i_clk);
            i_cfg_we = 1'b1;
            i_cfg_addr = (i == 0) ? rbsi_pkg::CFG_SIZE_X :
                         (i == 1) ? rbsi_pkg::CFG_SIZE_Y : rbsi_pkg::CFG_SIZE_Z;
            i_cfg_data = box[i];
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] rand_dir();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom;
            default: return ($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(0, DIR_ONE));
        endcase
    endfunction

    function automatic logic [31:0] rand_coord(logic [rbsi_pkg::LEN_W-1:0] sz, bit outside);
        int span;
        span = $urandom_range(1, 64 * UNIT);
        if (!outside) return $urandom_range(0, sz);
        return $urandom_range(0, 1) ? -span : int'(sz) + span;
    endfunction

    task automatic send_random();
        logic [1:0] op;
        logic [31:0] p [3];
        logic [31:0] seg;
        int kind;
        kind = $urandom_range(0, 9);
        op = 2'($urandom_range(0, 2));
        for (int i = 0; i < 3; i++)
            p[i] = rand_coord(box[i], op == rbsi_pkg::OP_ENTRY && $urandom_range(0, 1));
        seg = $urandom_range(0, 1) ? $urandom_range(0, 128 * UNIT) : $urandom;
        if (kind == 0) begin
            send_ray(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
        end else begin
            send_ray(op, p[0], p[1], p[2], rand_dir(), rand_dir(), rand_dir(), seg);
        end
    endtask

    initial begin
        i_rst_n = 0; i_cfg_we = 0; i_cfg_addr = '0; i_cfg_data = '0;
        i_in_valid = 0; i_operation = '0;
        i_pos_x = '0; i_pos_y = '0; i_pos_z = '0;
        i_dir_x = '0; i_dir_y = '0; i_dir_z = '0; i_seg_length = '0;
        burst_left = 0;
        box[0] = '0; box[1] = '0; box[2] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed rays in a 10 cm cube
        set_box(10 * UNIT, 10 * UNIT, 10 * UNIT);
        send_ray(rbsi_pkg::OP_CONTAIN, 0, 0, 0, 0, 0, 0, 0);
        send_ray(rbsi_pkg::OP_CONTAIN, 10 * UNIT, 10 * UNIT, 10 * UNIT, 0, 0, 0, 0);
        send_ray(rbsi_pkg::OP_CONTAIN, -1, 5 * UNIT, 5 * UNIT, 0, 0, 0, 0);
        send_ray(rbsi_pkg::OP_CONTAIN, 10 * UNIT + 1, 0, 0, 0, 0, 0, 0);
        send_ray(OP_NONE, 5 * UNIT, 5 * UNIT, 5 * UNIT, DIR_ONE, 0, 0, 20 * UNIT);
        send_ray(rbsi_pkg::OP_EXIT, 5 * UNIT, 5 * UNIT, 5 * UNIT, DIR_ONE, 0, 0, 20 * UNIT);
        send_ray(rbsi_pkg::OP_EXIT, 5 * UNIT, 5 * UNIT, 5 * UNIT, 0, DIR_ONE, 0, 2 * UNIT);
        send_ray(rbsi_pkg::OP_EXIT, 5 * UNIT, 5 * UNIT, 5 * UNIT, 0, 0, 0, 20 * UNIT);
        send_ray(rbsi_pkg::OP_EXIT, 5 * UNIT, 5 * UNIT, 5 * UNIT, 0, 0, -DIR_ONE, 20 * UNIT);
        send_ray(rbsi_pkg::OP_EXIT, 20 * UNIT, 5 * UNIT, 5 * UNIT, -DIR_ONE, 0, 0, 20 * UNIT);
        send_ray(rbsi_pkg::OP_EXIT, 5 * UNIT, 5 * UNIT, 5 * UNIT, 1, 1, 1, '1);
        send_ray(rbsi_pkg::OP_EXIT, 32'h7FFF_FFFF, 32'h8000_0000, 5 * UNIT,
                 32'h8000_0000, 32'h7FFF_FFFF, 1, '1);
        send_ray(rbsi_pkg::OP_ENTRY, -5 * UNIT, 5 * UNIT, 5 * UNIT, DIR_ONE, 0, 0, 20 * UNIT);
        send_ray(rbsi_pkg::OP_ENTRY, -5 * UNIT, 5 * UNIT, 5 * UNIT, DIR_ONE, 0, 0, 2 * UNIT);
        send_ray(rbsi_pkg::OP_ENTRY, 15 * UNIT, -5 * UNIT, 5 * UNIT, -DIR_ONE, DIR_ONE, 0,
                 40 * UNIT);
        send_ray(rbsi_pkg::OP_ENTRY, 5 * UNIT, 5 * UNIT, 15 * UNIT, 0, 0, -DIR_ONE, 40 * UNIT);
        send_ray(rbsi_pkg::OP_ENTRY, -5 * UNIT, 5 * UNIT, 5 * UNIT, 0, DIR_ONE, 0, 40 * UNIT);
        send_ray(rbsi_pkg::OP_ENTRY, -5 * UNIT, 20 * UNIT, 5 * UNIT, DIR_ONE, 0, 0, '1);
        send_ray(rbsi_pkg::OP_ENTRY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, 1, '1);
        send_ray(rbsi_pkg::OP_ENTRY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
        drain_idle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_box('0, '0, '0);
                1: set_box('1, '1, '1);
                2: set_box(1, 1, 1);
                3: set_box($urandom_range(1, 32 * UNIT), $urandom_range(1, 32 * UNIT),
                           $urandom_range(1, 32 * UNIT));
                4: set_box($urandom, $urandom, $urandom);
                default: set_box(16 * UNIT, 4 * UNIT, 64 * UNIT);
            endcase
            for (int n = 0; n < 330; n++) begin
                send_random();
                if (ph == 3 && n == 150) drain_idle();
            end
            drain_idle();
        end

        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
